[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level of the telnet option negotiator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hw/rtl/tnon_pkg.sv]
// Package with the byte codes and shared types of the telnet option negotiator.
package tnon_pkg;

   // Telnet command bytes.
   localparam logic [7:0] TN_IAC  = 8'd255;
   localparam logic [7:0] TN_DONT = 8'd254;
   localparam logic [7:0] TN_DO   = 8'd253;
   localparam logic [7:0] TN_WONT = 8'd252;
   localparam logic [7:0] TN_WILL = 8'd251;
   localparam logic [7:0] TN_SB   = 8'd250;
   localparam logic [7:0] TN_SE   = 8'd240;

   // Option numbers that this block knows.
   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SGA  = 8'd3;

   // Beats in one reply: IAC, reply code, option.
   localparam logic [1:0] REPLY_BEATS = 2'd3;

   // Destination flag of a result.
   localparam logic DEST_CLI  = 1'b0;
   localparam logic DEST_PEER = 1'b1;

   // What one received byte produces.
   typedef enum logic [1:0] {
      RES_NONE,
      RES_DATA,
      RES_REPLY
   } res_kind_type;

   // Result descriptor handed from the parser to the output stage.
   typedef struct packed {
      res_kind_type kind;
      logic [7:0]   reply_code;
      logic [7:0]   data_byte;
      logic         echo_on;
      logic         sga_on;
   } res_desc_type;

endpackage

[hw/rtl/tnon_parser.sv]
// Command parser: holds the telnet parse state and option flags, decodes each request byte.
module tnon_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   output tnon_pkg::res_desc_type desc
);

   logic       in_command_ff, in_command_in;
   logic [1:0] byte_position_ff, byte_position_in;
   logic       in_subneg_ff, in_subneg_in;
   logic [7:0] command_code_ff, command_code_in;
   logic [7:0] previous_byte_ff, previous_byte_in;
   logic       echo_flag_ff, echo_flag_in;
   logic       sga_flag_ff, sga_flag_in;

   // Parse state registers, updated only when a request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_command_ff    <= 1'b0;
         byte_position_ff <= 2'd0;
         in_subneg_ff     <= 1'b0;
         command_code_ff  <= 8'd0;
         previous_byte_ff <= 8'd0;
         echo_flag_ff     <= 1'b1;
         sga_flag_ff      <= 1'b0;
      end else if (accept) begin
         in_command_ff    <= in_command_in;
         byte_position_ff <= byte_position_in;
         in_subneg_ff     <= in_subneg_in;
         command_code_ff  <= command_code_in;
         previous_byte_ff <= previous_byte_in;
         echo_flag_ff     <= echo_flag_in;
         sga_flag_ff      <= sga_flag_in;
      end
   end

   // Next parse state and the result that this byte causes.
   always_comb begin
      in_command_in    = in_command_ff;
      byte_position_in = byte_position_ff;
      in_subneg_in     = in_subneg_ff;
      command_code_in  = command_code_ff;
      previous_byte_in = rx_byte;
      echo_flag_in     = echo_flag_ff;
      sga_flag_in      = sga_flag_ff;
      desc.kind        = tnon_pkg::RES_NONE;
      desc.reply_code  = tnon_pkg::TN_WONT;
      desc.data_byte   = rx_byte;

      if (!in_command_ff) begin
         // Data mode: IAC opens a command, anything else goes to the command line.
         if (rx_byte == tnon_pkg::TN_IAC) begin
            in_command_in    = 1'b1;
            byte_position_in = 2'd1;
            in_subneg_in     = 1'b0;
         end else begin
            desc.kind = tnon_pkg::RES_DATA;
         end
      end else if (byte_position_ff == 2'd1) begin
         // Command code byte.
         command_code_in  = rx_byte;
         in_subneg_in     = (rx_byte == tnon_pkg::TN_SB);
         byte_position_in = 2'd2;
      end else if (in_subneg_ff) begin
         // Subnegotiation is skipped until IAC SE.
         if (previous_byte_ff == tnon_pkg::TN_IAC && rx_byte == tnon_pkg::TN_SE) begin
            in_subneg_in     = 1'b0;
            in_command_in    = 1'b0;
            byte_position_in = 2'd0;
         end else if (byte_position_ff != 2'd3) begin
            byte_position_in = byte_position_ff + 2'd1;
         end
      end else begin
         // Option byte of an ordinary command.
         in_command_in    = 1'b0;
         byte_position_in = 2'd0;
         case (command_code_ff)
            tnon_pkg::TN_DO: begin
               desc.kind = tnon_pkg::RES_REPLY;
               if (rx_byte == tnon_pkg::OPT_ECHO) begin
                  echo_flag_in    = 1'b1;
                  desc.reply_code = tnon_pkg::TN_WILL;
               end else if (rx_byte == tnon_pkg::OPT_SGA) begin
                  sga_flag_in     = 1'b1;
                  desc.reply_code = tnon_pkg::TN_WILL;
               end
            end
            tnon_pkg::TN_DONT: begin
               desc.kind = tnon_pkg::RES_REPLY;
               if (rx_byte == tnon_pkg::OPT_ECHO) begin
                  echo_flag_in = 1'b0;
               end else if (rx_byte == tnon_pkg::OPT_SGA) begin
                  sga_flag_in = 1'b0;
               end
            end
            default: begin
               desc.kind = tnon_pkg::RES_NONE;
            end
         endcase
      end

      desc.echo_on = echo_flag_in;
      desc.sga_on  = sga_flag_in;
   end

endmodule

[hw/rtl/telnet_option_negotiator.sv]
// Top level of the telnet option negotiator: request parser and result burst register.
//
//   Channel | Direction | Ports            | Payload
//   --------+-----------+------------------+----------------------------------------
//   req     | in        | req_t*           | tdata: rx_byte
//   rsp     | out       | rsp_t*           | tdata: out_byte, echo_on, go_ahead_suppressed;
//           |           |                  | tuser: destination; tlast: last_of_run
//
// A request byte is decoded in the cycle it is taken; its results appear on rsp
// from the next cycle. Data bytes sustain one request per cycle while rsp is
// ready. A reply holds the result register for three beats, so req_tready is
// low until its last beat is taken. Bytes that cause no result only update the
// parse state. Reset is synchronous and active high; it restores data mode with
// echo on. A stall on rsp holds req_tready low once the result register is occupied.
`include "assert_macros.svh"

module telnet_option_negotiator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] echo_on,
                                    // [9] go_ahead_suppressed, [15:10] zero
   output logic        rsp_tuser,   // [0] destination
   output logic        rsp_tlast    // last_of_run
);

   tnon_pkg::res_desc_type desc;
   logic                   req_accept;
   logic                   rsp_accept;
   logic [7:0]             out_byte;

   logic [1:0] beats_ff, beats_in;
   logic [7:0] reply_code_ff, reply_code_in;
   logic [7:0] last_byte_ff, last_byte_in;
   logic       dest_ff, dest_in;
   logic       echo_ff, echo_in;
   logic       sga_ff, sga_in;

   // Handshakes: a new request may enter as the final beat leaves.
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign req_tready = (beats_ff == 2'd0) || (beats_ff == 2'd1 && rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   tnon_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_tdata),
      .desc    (desc)
   );

   // Result burst register: load on a request, count down on each beat taken.
   always_comb begin
      beats_in      = beats_ff;
      reply_code_in = reply_code_ff;
      last_byte_in  = last_byte_ff;
      dest_in       = dest_ff;
      echo_in       = echo_ff;
      sga_in        = sga_ff;
      if (req_accept) begin
         reply_code_in = desc.reply_code;
         last_byte_in  = desc.data_byte;
         echo_in       = desc.echo_on;
         sga_in        = desc.sga_on;
         case (desc.kind)
            tnon_pkg::RES_DATA: begin
               beats_in = 2'd1;
               dest_in  = tnon_pkg::DEST_CLI;
            end
            tnon_pkg::RES_REPLY: begin
               beats_in = tnon_pkg::REPLY_BEATS;
               dest_in  = tnon_pkg::DEST_PEER;
            end
            default: begin
               beats_in = 2'd0;
            end
         endcase
      end else if (rsp_accept) begin
         beats_in = beats_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beats_ff <= 2'd0;
      end else begin
         beats_ff <= beats_in;
      end
   end

   always_ff @(posedge clock) begin
      reply_code_ff <= reply_code_in;
      last_byte_ff  <= last_byte_in;
      dest_ff       <= dest_in;
      echo_ff       <= echo_in;
      sga_ff        <= sga_in;
   end

   // Beat selection: IAC, then the reply code, then the option or data byte.
   always_comb begin
      case (beats_ff)
         2'd3:    out_byte = tnon_pkg::TN_IAC;
         2'd2:    out_byte = reply_code_ff;
         default: out_byte = last_byte_ff;
      endcase
   end

   assign rsp_tdata  = {6'd0, sga_ff, echo_ff, out_byte};
   assign rsp_tuser  = dest_ff;
   assign rsp_tlast  = (beats_ff == 2'd1);
   assign rsp_tvalid = (beats_ff != 2'd0);

   // A data byte taken from req shows up as a single command-line beat.
   `ASSERT_NEXT_CYCLE(a_data_single_beat, clock, reset,
      req_accept && desc.kind == tnon_pkg::RES_DATA,
      rsp_tvalid && rsp_tuser == tnon_pkg::DEST_CLI && rsp_tlast)
   // A reply opens with IAC toward the peer.
   `ASSERT_NEXT_CYCLE(a_reply_starts_iac, clock, reset,
      req_accept && desc.kind == tnon_pkg::RES_REPLY,
      rsp_tvalid && rsp_tuser == tnon_pkg::DEST_PEER && rsp_tdata[7:0] == tnon_pkg::TN_IAC)
   // A reply beat that leaves, short of the last, is followed by the next beat.
   `ASSERT_NEXT_CYCLE(a_reply_advances, clock, reset,
      rsp_accept && !rsp_tlast,
      rsp_tvalid && rsp_tuser == tnon_pkg::DEST_PEER)
   // Command-line beats are never part of a longer burst.
   `ASSERT_SAME_CYCLE(a_cli_is_last, clock, reset,
      rsp_tvalid && rsp_tuser == tnon_pkg::DEST_CLI,
      rsp_tlast)

endmodule

[dv/tb_telnet_option_negotiator.sv]
// Testbench for the telnet option negotiator: byte stream stimulus, reply prediction and checks.
module tb_telnet_option_negotiator;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] out_byte, [8] echo_on, [9] go_ahead_suppressed
   logic        rsp_tuser;           // [0] destination
   logic        rsp_tlast;           // last_of_run

   // One result beat as it should leave the block.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       dest;
      logic       last;
      logic       echo;
      logic       sga;
   } nego_beat_type;

   nego_beat_type expected_beats[$];
   int            error_count = 0;
   bit            sender_idles = 1'b0;
   bit            receiver_stalls = 1'b0;
   int            stall_left = 0;

   // Parser state of the prediction, mirrored from the block's behavior.
   logic       in_cmd = 1'b0;
   logic [1:0] cmd_pos = 2'd0;
   logic       in_sub = 1'b0;
   logic [7:0] cmd_code = 8'h00;
   logic [7:0] prev_rx = 8'h00;
   logic       echo_flag = 1'b1;
   logic       sga_flag = 1'b0;

   telnet_option_negotiator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void queue_beat(input logic [7:0] b, input logic dest, input logic last);
      nego_beat_type beat;
      beat.out_byte = b;
      beat.dest     = dest;
      beat.last     = last;
      beat.echo     = echo_flag;
      beat.sga      = sga_flag;
      expected_beats.push_back(beat);
   endfunction

   // Advance the parse state by one received byte and queue the beats it causes.
   function automatic void predict_rx_byte(input logic [7:0] c);
      logic [7:0] last_rx;
      logic [7:0] answer;
      last_rx = prev_rx;
      prev_rx = c;
      answer  = 8'h00;
      if (!in_cmd) begin
         if (c == tnon_pkg::TN_IAC) begin
            in_cmd  = 1'b1;
            cmd_pos = 2'd1;
            in_sub  = 1'b0;
         end else begin
            queue_beat(c, tnon_pkg::DEST_CLI, 1'b1);
         end
      end else if (cmd_pos == 2'd1) begin
         cmd_code = c;
         in_sub   = (c == tnon_pkg::TN_SB);
         cmd_pos  = 2'd2;
      end else if (in_sub) begin
         // Subnegotiation ends only on SE right after IAC; the position saturates.
         if (last_rx == tnon_pkg::TN_IAC && c == tnon_pkg::TN_SE) begin
            in_sub  = 1'b0;
            in_cmd  = 1'b0;
            cmd_pos = 2'd0;
         end else if (cmd_pos < 2'd3) begin
            cmd_pos = cmd_pos + 2'd1;
         end
      end else begin
         // Option byte of an ordinary command.
         if (cmd_code == tnon_pkg::TN_DO) begin
            answer = tnon_pkg::TN_WILL;
            if (c == tnon_pkg::OPT_ECHO) echo_flag = 1'b1;
            else if (c == tnon_pkg::OPT_SGA) sga_flag = 1'b1;
            else answer = tnon_pkg::TN_WONT;
         end else if (cmd_code == tnon_pkg::TN_DONT) begin
            answer = tnon_pkg::TN_WONT;
            if (c == tnon_pkg::OPT_ECHO) echo_flag = 1'b0;
            else if (c == tnon_pkg::OPT_SGA) sga_flag = 1'b0;
         end
         in_cmd  = 1'b0;
         cmd_pos = 2'd0;
         if (answer != 8'h00) begin
            queue_beat(tnon_pkg::TN_IAC, tnon_pkg::DEST_PEER, 1'b0);
            queue_beat(answer, tnon_pkg::DEST_PEER, 1'b0);
            queue_beat(c, tnon_pkg::DEST_PEER, 1'b1);
         end
      end
   endfunction

   // Send one request byte and wait until the block takes it.
   task automatic send_rx_byte(input logic [7:0] b);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_rx_byte(b);
      gap = sender_idles ? gap_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_command(input logic [7:0] code, input logic [7:0] option);
      send_rx_byte(tnon_pkg::TN_IAC);
      send_rx_byte(code);
      send_rx_byte(option);
   endtask

   // Hold off new requests until every queued beat has come out.
   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic note_mismatch(input string what, input nego_beat_type want,
                                input nego_beat_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("%t: %s: expected byte %02h dest %0d last %0d echo %0d sga %0d,",
                  $realtime, what, want.out_byte, want.dest, want.last, want.echo, want.sga);
         $display("   got byte %02h dest %0d last %0d echo %0d sga %0d",
                  got.out_byte, got.dest, got.last, got.echo, got.sga);
      end
   endtask

   // Receiver back-pressure: random stalls, mostly short, sometimes long.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare every accepted result beat with the oldest expectation.
   always @(posedge clock) begin : check_beats
      nego_beat_type got;
      nego_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_byte = rsp_tdata[7:0];
         got.dest     = rsp_tuser;
         got.last     = rsp_tlast;
         got.echo     = rsp_tdata[8];
         got.sga      = rsp_tdata[9];
         if (expected_beats.size() == 0) begin
            note_mismatch("result with nothing outstanding", '0, got);
         end else begin
            want = expected_beats.pop_front();
            if (got.out_byte !== want.out_byte) note_mismatch("out_byte differs", want, got);
            else if (got.dest !== want.dest) note_mismatch("destination differs", want, got);
            else if (got.last !== want.last) note_mismatch("last_of_run differs", want, got);
            else if (got.echo !== want.echo) note_mismatch("echo_on differs", want, got);
            else if (got.sga !== want.sga) note_mismatch("go_ahead_suppressed differs", want, got);
         end
      end
   end

   // Plain data bytes at the edges of the range.
   task automatic test_data_bytes();
      send_rx_byte(8'h00);
      send_rx_byte(8'hFE);
   endtask

   // DO and DONT for known options, and DO for an unknown one.
   task automatic test_option_requests();
      send_command(tnon_pkg::TN_DONT, tnon_pkg::OPT_ECHO);
      send_command(tnon_pkg::TN_DO, tnon_pkg::OPT_SGA);
      send_command(tnon_pkg::TN_DO, 8'hFF);
      send_command(tnon_pkg::TN_DONT, tnon_pkg::OPT_SGA);
   endtask

   // WILL is absorbed, and IAC inside a command is taken as the command code.
   task automatic test_absorbed_commands();
      send_command(tnon_pkg::TN_WILL, tnon_pkg::OPT_ECHO);
      send_command(tnon_pkg::TN_IAC, 8'h05);
   endtask

   // Subnegotiation with one body byte, ended by IAC SE, then data mode again.
   task automatic test_subnegotiation();
      send_rx_byte(tnon_pkg::TN_IAC);
      send_rx_byte(tnon_pkg::TN_SB);
      send_rx_byte(8'h18);
      send_rx_byte(tnon_pkg::TN_IAC);
      send_rx_byte(tnon_pkg::TN_SE);
      send_rx_byte(8'h01);
   endtask

   function automatic logic [7:0] pick_option();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return tnon_pkg::OPT_ECHO;
      if (roll < 8) return tnon_pkg::OPT_SGA;
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly well-formed command sequences with random content, plus noise.
   task automatic test_random_stream(input int count);
      int sent;
      int roll;
      int body;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 25) begin
            send_rx_byte(8'($urandom_range(0, 254)));
            sent += 1;
         end else if (roll < 60) begin
            send_command($urandom_range(0, 1) ? tnon_pkg::TN_DO : tnon_pkg::TN_DONT,
                         pick_option());
            sent += 3;
         end else if (roll < 70) begin
            case ($urandom_range(0, 2))
               0: send_command(tnon_pkg::TN_WILL, pick_option());
               1: send_command(tnon_pkg::TN_WONT, pick_option());
               default: send_command(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            sent += 3;
         end else if (roll < 82) begin
            body = $urandom_range(0, 6);
            send_rx_byte(tnon_pkg::TN_IAC);
            send_rx_byte(tnon_pkg::TN_SB);
            repeat (body) send_rx_byte(8'($urandom_range(0, 255)));
            send_rx_byte(tnon_pkg::TN_IAC);
            send_rx_byte(tnon_pkg::TN_SE);
            sent += body + 4;
         end else begin
            send_rx_byte(8'($urandom_range(0, 255)));
            sent += 1;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_data_bytes();
      test_option_requests();
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      test_absorbed_commands();
      test_subnegotiation();
      wait_for_replies();

      // Random phases with and without idling on either side.
      test_random_stream(50);
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      test_random_stream(35);
      wait_for_replies();
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      test_random_stream(60);
      sender_idles = 1'b0;
      test_random_stream(35);

      wait_for_replies();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #24000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[telnet_option_negotiator.f]
+incdir+hw/rtl
hw/rtl/tnon_pkg.sv
hw/rtl/tnon_parser.sv
hw/rtl/telnet_option_negotiator.sv
dv/tb_telnet_option_negotiator.sv
